// ===== hw/rtl/rbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared widths, defaults and verdict codes for the range background
// subtraction block.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int IDX_W   = 14;
    localparam int COORD_W = 18;
    localparam int SQ_W    = 36;            // x^2 + y^2 + z^2 < 2^36
    localparam int HALF_W  = SQ_W / 2;      // split of bg range for the multiply
    localparam int RATIO_W = 16;
    localparam int A_W     = RATIO_W + 1;   // 1.0 - ratio, up to 2^16
    localparam int A2_W    = 2 * RATIO_W + 1;
    localparam int PROD_W  = A2_W + HALF_W;
    localparam int CMP_W   = A2_W + SQ_W;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd6554;   // 0.1 in Q0.16
    localparam int POINTS_PER_FRAME_DEF = 16384;

    typedef enum logic [1:0]
    {
        VERDICT_LEARN  = 2'd0,
        VERDICT_KEEP   = 2'd1,
        VERDICT_REMOVE = 2'd2
    } verdict_t;

endpackage

// ===== hw/rtl/rbs_ram.sv =====
// ----------------------------------------------------------------------------
// rbs_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module rbs_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/range_background_subtract.sv =====
// Path: the stage 1 to 4 registers, then the output register, lead to m_axis.
// Throughput: one item per cycle while the skid is empty; the per-index background
// RAM read-modify-write is closed by forwarding from the two stages after the write.
// Reset: control, frame length and learned flag clear, min_ratio returns to
// 0.1 (6554); the background RAM is not cleared, the first frame refills it.
// ----------------------------------------------------------------------------
// range_background_subtract
// Lidar point background subtraction against a learned first frame.
// ----------------------------------------------------------------------------
module range_background_subtract
    import rbs_pkg::*;
#(
    parameter int POINTS_PER_FRAME = POINTS_PER_FRAME_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RATIO_W-1:0] cfg_data,        // min_ratio

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [71:0]        s_axis_tdata,    // point_index, coord_x, coord_y, coord_z
    input  logic               s_axis_tuser,    // point_valid
    input  logic               s_axis_tlast,    // frame_end

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata,    // out_index, verdict
    output logic               m_axis_tlast     // out_frame_end
);

    localparam int RAM_DEPTH = (POINTS_PER_FRAME < 2**IDX_W) ? POINTS_PER_FRAME : 2**IDX_W;
    localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int LEN_W     = $clog2(POINTS_PER_FRAME + 1);
    localparam logic [31:0] PPF_U32 = 32'(POINTS_PER_FRAME);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(POINTS_PER_FRAME);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [RATIO_W-1:0] min_ratio_reg;
    logic [A_W-1:0]     a_val;
    logic [A2_W-1:0]    a2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_ratio_reg <= RATIO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            min_ratio_reg <= cfg_data;
        end
    end

    assign a_val = A_W'(2**RATIO_W) - A_W'(min_ratio_reg);

    // (1 - r)^2, registered from min_ratio_reg; it settles in the cycle after a write
    always_ff @(posedge clk)
    begin
        a2_reg <= A2_W'(a_val) * A2_W'(a_val);
    end

    // ------------------------------------------------------------------
    // pipeline enable: whole pipe moves unless the output skid is full
    // ------------------------------------------------------------------
    logic en;
    logic skid_valid_reg;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // stage 1: input register, squares
    // ------------------------------------------------------------------
    logic                      s1_valid_reg;
    logic [IDX_W-1:0]          s1_idx_reg;
    logic signed [COORD_W-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic                      s1_pv_reg, s1_fend_reg;

    logic [COORD_W-1:0] mag_x, mag_y, mag_z;
    logic [SQ_W-1:0]    sq_x, sq_y, sq_z;

    logic [SQ_W:0]      ram_rd_data;    // {ok, range_sq}
    logic               ram_wr_en;
    logic [SQ_W:0]      ram_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_idx_reg  <= s_axis_tdata[13:0];
            s1_x_reg    <= s_axis_tdata[31:14];
            s1_y_reg    <= s_axis_tdata[49:32];
            s1_z_reg    <= s_axis_tdata[67:50];
            s1_pv_reg   <= s_axis_tuser;
            s1_fend_reg <= s_axis_tlast;
        end
    end

    assign mag_x = s1_x_reg[COORD_W-1] ? COORD_W'(-s1_x_reg) : COORD_W'(s1_x_reg);
    assign mag_y = s1_y_reg[COORD_W-1] ? COORD_W'(-s1_y_reg) : COORD_W'(s1_y_reg);
    assign mag_z = s1_z_reg[COORD_W-1] ? COORD_W'(-s1_z_reg) : COORD_W'(s1_z_reg);

    assign sq_x = SQ_W'(mag_x) * SQ_W'(mag_x);
    assign sq_y = SQ_W'(mag_y) * SQ_W'(mag_y);
    assign sq_z = SQ_W'(mag_z) * SQ_W'(mag_z);

    // ------------------------------------------------------------------
    // stage 2: range sum, forwarded background, update decision
    // ------------------------------------------------------------------
    logic                 s2_valid_reg;
    logic [IDX_W-1:0]     s2_idx_reg;
    logic                 s2_pv_reg, s2_fend_reg;
    logic [SQ_W-1:0]      s2_sqx_reg, s2_sqy_reg, s2_sqz_reg;

    logic                 learned_reg;
    logic [LEN_W-1:0]     bg_len_reg;

    // stage 3 / 4 registers used for forwarding
    logic                 s3_valid_reg;
    logic [IDX_W-1:0]     s3_idx_reg;
    logic                 s3_fend_reg;
    verdict_t             s3_verdict_reg;
    logic                 s3_check_reg;
    logic [SQ_W-1:0]      s3_in_sq_reg;
    logic [SQ_W-1:0]      s3_bg_sq_reg;
    logic                 s3_we_reg;
    logic [SQ_W:0]        s3_wdata_reg;

    logic                 s4_valid_reg;
    logic [IDX_W-1:0]     s4_idx_reg;
    logic                 s4_fend_reg;
    verdict_t             s4_verdict_reg;
    logic                 s4_check_reg;
    logic [SQ_W-1:0]      s4_in_sq_reg;
    logic [PROD_W-1:0]    s4_p_lo_reg, s4_p_hi_reg;
    logic                 s4_we_reg;
    logic [SQ_W:0]        s4_wdata_reg;

    logic [SQ_W-1:0]      in_sq;
    logic [SQ_W:0]        bg_word;
    logic                 idx_lt_ppf, idx_lt_len;
    logic                 wr_req;
    logic [SQ_W:0]        wr_word;
    verdict_t             s2_verdict;
    logic                 s2_check;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_idx_reg  <= s1_idx_reg;
            s2_pv_reg   <= s1_pv_reg;
            s2_fend_reg <= s1_fend_reg;
            s2_sqx_reg  <= sq_x;
            s2_sqy_reg  <= sq_y;
            s2_sqz_reg  <= sq_z;
        end
    end

    assign in_sq = s2_sqx_reg + s2_sqy_reg + s2_sqz_reg;

    // the write from the item in stage 3 is not yet visible in the RAM read; stage 4 is also forwarded
    always_comb
    begin
        if (s3_valid_reg && s3_we_reg && (s3_idx_reg == s2_idx_reg))
        begin
            bg_word = s3_wdata_reg;
        end
        else if (s4_valid_reg && s4_we_reg && (s4_idx_reg == s2_idx_reg))
        begin
            bg_word = s4_wdata_reg;
        end
        else
        begin
            bg_word = ram_rd_data;
        end
    end

    assign idx_lt_ppf = 32'(s2_idx_reg) < PPF_U32;
    assign idx_lt_len = 32'(s2_idx_reg) < 32'(bg_len_reg);

    always_comb
    begin
        wr_req     = 1'b0;
        wr_word    = {1'b1, in_sq};
        s2_verdict = VERDICT_KEEP;
        s2_check   = 1'b0;
        if (!learned_reg)
        begin
            s2_verdict = VERDICT_LEARN;
            wr_req     = idx_lt_ppf;
            wr_word    = s2_pv_reg ? {1'b1, in_sq} : '0;
        end
        else if (idx_lt_len && s2_pv_reg)
        begin
            if (!bg_word[SQ_W])
            begin
                wr_req = 1'b1;
            end
            else if (in_sq > bg_word[SQ_W-1:0])
            begin
                wr_req     = 1'b1;
                s2_verdict = VERDICT_REMOVE;
            end
            else
            begin
                s2_check = 1'b1;
            end
        end
    end

    assign ram_wr_en   = en && s2_valid_reg && wr_req;
    assign ram_wr_data = wr_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learned_reg <= 1'b0;
            bg_len_reg  <= '0;
        end
        else if (en && s2_valid_reg && !learned_reg)
        begin
            if (bg_len_reg != LEN_MAX)
            begin
                bg_len_reg <= bg_len_reg + LEN_W'(1);
            end
            if (s2_fend_reg)
            begin
                learned_reg <= 1'b1;
            end
        end
    end

    // read as the item moves from stage 1 to stage 2
    rbs_ram
    #(
        .WIDTH (SQ_W + 1),
        .DEPTH (RAM_DEPTH)
    )
    u_bg_ram
    (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ADDR_W'(s2_idx_reg)),
        .wr_data (ram_wr_data),
        .rd_en   (en),
        .rd_addr (ADDR_W'(s1_idx_reg)),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // stage 3: partial products of (1-r)^2 * bg
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] p_lo, p_hi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_idx_reg     <= s2_idx_reg;
            s3_fend_reg    <= s2_fend_reg;
            s3_verdict_reg <= s2_verdict;
            s3_check_reg   <= s2_check;
            s3_in_sq_reg   <= in_sq;
            s3_bg_sq_reg   <= bg_word[SQ_W-1:0];
            s3_we_reg      <= s2_valid_reg && wr_req;
            s3_wdata_reg   <= wr_word;
        end
    end

    assign p_lo = PROD_W'(a2_reg) * PROD_W'(s3_bg_sq_reg[HALF_W-1:0]);
    assign p_hi = PROD_W'(a2_reg) * PROD_W'(s3_bg_sq_reg[SQ_W-1:HALF_W]);

    // ------------------------------------------------------------------
    // stage 4: in^2 * 2^32 > (1-r)^2 * bg^2 (scaled by 2^32)
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] rhs, lhs;
    logic             near;
    verdict_t         s4_verdict;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_idx_reg     <= s3_idx_reg;
            s4_fend_reg    <= s3_fend_reg;
            s4_verdict_reg <= s3_verdict_reg;
            s4_check_reg   <= s3_check_reg;
            s4_in_sq_reg   <= s3_in_sq_reg;
            s4_p_lo_reg    <= p_lo;
            s4_p_hi_reg    <= p_hi;
            s4_we_reg      <= s3_we_reg;
            s4_wdata_reg   <= s3_wdata_reg;
        end
    end

    assign rhs  = CMP_W'(s4_p_lo_reg) + CMP_W'({s4_p_hi_reg, {HALF_W{1'b0}}});
    assign lhs  = CMP_W'({s4_in_sq_reg, {(2 * RATIO_W){1'b0}}});
    assign near = lhs > rhs;

    always_comb
    begin
        s4_verdict = s4_verdict_reg;
        if (s4_check_reg)
        begin
            s4_verdict = near ? VERDICT_REMOVE : VERDICT_KEEP;
        end
    end

    // ------------------------------------------------------------------
    // output register with skid entry
    // ------------------------------------------------------------------
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_idx_reg, skid_idx_reg;
    verdict_t         out_verdict_reg, skid_verdict_reg;
    logic             out_fend_reg, skid_fend_reg;
    logic             new_item;
    logic             out_free;

    assign new_item = en && s4_valid_reg;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (m_axis_tready)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (new_item)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_idx_reg     <= skid_idx_reg;
                out_verdict_reg <= skid_verdict_reg;
                out_fend_reg    <= skid_fend_reg;
            end
        end
        else if (new_item)
        begin
            if (out_free)
            begin
                out_idx_reg     <= s4_idx_reg;
                out_verdict_reg <= s4_verdict;
                out_fend_reg    <= s4_fend_reg;
            end
            else
            begin
                skid_idx_reg     <= s4_idx_reg;
                skid_verdict_reg <= s4_verdict;
                skid_fend_reg    <= s4_fend_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_verdict_reg, out_idx_reg};
    assign m_axis_tlast  = out_fend_reg;

endmodule

// ===== dv/tb_range_background_subtract.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_range_background_subtract
// Self-checking bench for the lidar background subtraction block. A short
// table learns a small background frame and hits the edge cases, then random
// points, mostly aimed near the removal threshold of each learned entry, run
// under several min_ratio settings and sender/receiver idle patterns. Every
// result is checked against its table verdict or an in-bench background model.
// ----------------------------------------------------------------------------
module tb_range_background_subtract;
    import rbs_pkg::*;

    localparam int LEARN_LEN  = 12;        // points in the learned frame
    localparam int PHASE_PTS  = 110;
    localparam int CYCLE_MAX  = 400000;
    localparam int DRAIN_CYC  = 12;        // covers the stage and output registers of the pipeline

    typedef struct {
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      ok;
        logic                      fend;
    } point_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        verdict_t         verdict;
        logic             fend;
    } result_t;

    typedef struct {
        point_t   pt;
        bit       typed;
        verdict_t verdict;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [RATIO_W-1:0] cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [71:0]       s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;
    logic              m_axis_tlast;

    // background model
    logic [SQ_W-1:0]           bg_sq [0:POINTS_PER_FRAME_DEF-1];
    bit                        bg_ok [0:POINTS_PER_FRAME_DEF-1];
    logic signed [COORD_W-1:0] bg_x [0:POINTS_PER_FRAME_DEF-1];
    logic signed [COORD_W-1:0] bg_y [0:POINTS_PER_FRAME_DEF-1];
    logic signed [COORD_W-1:0] bg_z [0:POINTS_PER_FRAME_DEF-1];
    int                        bg_len = 0;
    bit                        learned = 1'b0;
    logic [RATIO_W-1:0]        min_ratio = RATIO_RESET;

    result_t   verdict_q [$];
    stim_row_t point_table [$];
    int        fail_cnt = 0;
    int        cycle_cnt = 0;
    int        snd_pct = 0;
    int        rcv_pct = 0;
    int        snd_calm = 0;
    int        rcv_calm = 0;

    range_background_subtract u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_MAX)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver back-pressure, with calm stretches
    always @(posedge clk)
    begin
        if (rcv_calm > 0)
        begin
            rcv_calm = rcv_calm - 1;
            m_axis_tready <= 1'b1;
        end
        else
        begin
            if ($urandom_range(39) == 0)
                rcv_calm = $urandom_range(40, 10);
            m_axis_tready <= ($urandom_range(99) >= rcv_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result with nothing expected: out_index %0d", m_axis_tdata[13:0]);
                fail_cnt++;
            end
            else
            begin
                exp_r = verdict_q.pop_front();
                if (m_axis_tdata[13:0] !== exp_r.idx)
                begin
                    $error("out_index: expected %0d, got %0d", exp_r.idx, m_axis_tdata[13:0]);
                    fail_cnt++;
                end
                if (m_axis_tdata[15:14] !== exp_r.verdict)
                begin
                    $error("verdict: expected %0d, got %0d", exp_r.verdict,
                           m_axis_tdata[15:14]);
                    fail_cnt++;
                end
                if (m_axis_tlast !== exp_r.fend)
                begin
                    $error("out_frame_end: expected %0d, got %0d", exp_r.fend, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    function automatic void store_bg(point_t p, logic [SQ_W-1:0] sq, bit ok);
        bg_sq[p.idx] = sq;
        bg_ok[p.idx] = ok;
        bg_x[p.idx]  = ok ? p.x : '0;
        bg_y[p.idx]  = ok ? p.y : '0;
        bg_z[p.idx]  = ok ? p.z : '0;
    endfunction

    // verdict for one point; updates the background model
    function automatic verdict_t classify_point(point_t p);
        longint          mx;
        longint          my;
        longint          mz;
        logic [SQ_W-1:0] in_sq;
        logic [16:0]     a;
        logic [32:0]     a2;
        logic [68:0]     lhs;
        logic [68:0]     rhs;
        verdict_t        v;
        mx = (p.x < 0) ? -longint'(p.x) : longint'(p.x);
        my = (p.y < 0) ? -longint'(p.y) : longint'(p.y);
        mz = (p.z < 0) ? -longint'(p.z) : longint'(p.z);
        in_sq = SQ_W'(mx * mx + my * my + mz * mz);
        v = VERDICT_KEEP;
        if (!learned)
        begin
            v = VERDICT_LEARN;
            store_bg(p, p.ok ? in_sq : '0, p.ok);
            if (bg_len < POINTS_PER_FRAME_DEF)
                bg_len++;
            if (p.fend)
                learned = 1'b1;
        end
        else if (int'(p.idx) < bg_len && p.ok)
        begin
            if (!bg_ok[p.idx])
                store_bg(p, in_sq, 1'b1);
            else
            begin
                a   = 17'h10000 - {1'b0, min_ratio};
                a2  = 33'(a) * 33'(a);
                lhs = {1'b0, in_sq, 32'd0};
                rhs = 69'(a2) * 69'(bg_sq[p.idx]);
                if (in_sq > bg_sq[p.idx])
                begin
                    store_bg(p, in_sq, 1'b1);
                    v = VERDICT_REMOVE;
                end
                else if (lhs > rhs)
                    v = VERDICT_REMOVE;
            end
        end
        return v;
    endfunction

    function automatic void add_row(int idx, int x, int y, int z, bit ok, bit fend,
                                    bit typed, verdict_t v);
        stim_row_t r;
        r.pt.idx  = idx[IDX_W-1:0];
        r.pt.x    = x[COORD_W-1:0];
        r.pt.y    = y[COORD_W-1:0];
        r.pt.z    = z[COORD_W-1:0];
        r.pt.ok   = ok;
        r.pt.fend = fend;
        r.typed   = typed;
        r.verdict = v;
        point_table = {point_table, r};
    endfunction

    function automatic int sender_gap();
        int n;
        n = 0;
        if (snd_calm > 0)
            snd_calm--;
        else
        begin
            if ($urandom_range(39) == 0)
                snd_calm = $urandom_range(40, 10);
            while ($urandom_range(99) < snd_pct && n < 60)
                n++;
        end
        return n;
    endfunction

    // scale by k/65536 with a random sign flip, clamped to the coordinate range
    function automatic logic signed [COORD_W-1:0] scale_coord(logic signed [COORD_W-1:0] c,
                                                              longint k);
        longint v;
        v = (longint'(c) * k) / 65536;
        if ($urandom_range(1))
            v = -v;
        if (v > 131071)
            v = 131071;
        if (v < -131072)
            v = -131072;
        return v[COORD_W-1:0];
    endfunction

    function automatic point_t random_point();
        point_t p;
        int     kind;
        longint k;
        logic [31:0] r;
        kind   = $urandom_range(99);
        r      = $urandom;
        p.idx  = IDX_W'($urandom_range(LEARN_LEN - 1));
        p.ok   = 1'b1;
        p.fend = ($urandom_range(19) == 0);
        if (kind < 70)
        begin
            // near the threshold, or farther than the entry
            if (kind < 55)
                k = longint'(65536 - int'(min_ratio)) + longint'($urandom_range(1200)) - 600;
            else
                k = 65536 + longint'($urandom_range(16384, 1));
            if (k < 0)
                k = 0;
            p.x = scale_coord(bg_x[p.idx], k);
            p.y = scale_coord(bg_y[p.idx], k);
            p.z = scale_coord(bg_z[p.idx], k);
        end
        else
        begin
            p.x = r[COORD_W-1:0];
            p.y = COORD_W'($urandom);
            p.z = COORD_W'($urandom);
            if (kind >= 82)
            begin
                p.ok = 1'($urandom_range(1));
                if (kind < 94)
                    p.idx = IDX_W'($urandom);
                else
                    p.ok = 1'b0;
            end
        end
        return p;
    endfunction

    task automatic send_point(input point_t p, input bit typed, input verdict_t tv);
        int       gap;
        result_t  r;
        verdict_t pv;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, p.z, p.y, p.x, p.idx};
        s_axis_tuser  <= p.ok;
        s_axis_tlast  <= p.fend;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pv        = classify_point(p);
        r.idx     = p.idx;
        r.verdict = typed ? tv : pv;
        r.fend    = p.fend;
        verdict_q = {verdict_q, r};
    endtask

    task automatic write_ratio(input logic [RATIO_W-1:0] value);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        min_ratio = value;
    endtask

    initial
    begin
        int snd_mode [5];
        int rcv_mode [5];
        logic [RATIO_W-1:0] ratio_set [5];

        snd_mode  = '{0, 77, 0, 28, 0};
        rcv_mode  = '{0, 0, 77, 28, 0};
        ratio_set = '{16'd0, 16'hFFFF, RATIO_W'($urandom), RATIO_W'($urandom), RATIO_RESET};

        // learning frame: indices 0 .. LEARN_LEN-1, each exactly once
        add_row(0, 1000, 0, 0, 1, 0, 1, VERDICT_LEARN);
        add_row(1, -131072, -131072, -131072, 1, 0, 1, VERDICT_LEARN);
        add_row(2, 131071, 131071, 131071, 1, 0, 1, VERDICT_LEARN);
        add_row(3, 0, 0, 0, 1, 0, 1, VERDICT_LEARN);
        add_row(4, 5, 5, 5, 0, 0, 1, VERDICT_LEARN);
        add_row(5, 3000, 4000, 0, 1, 0, 1, VERDICT_LEARN);
        add_row(6, -2000, 1500, -700, 1, 0, 1, VERDICT_LEARN);
        add_row(7, 20000, -30000, 40000, 1, 0, 1, VERDICT_LEARN);
        add_row(8, 0, 0, 0, 0, 0, 1, VERDICT_LEARN);
        add_row(9, -1, -1, -1, 1, 0, 1, VERDICT_LEARN);
        add_row(10, 60000, 0, -60000, 1, 0, 1, VERDICT_LEARN);
        add_row(11, 777, -888, 999, 1, 1, 1, VERDICT_LEARN);
        // beyond the learned length
        add_row(16383, 131071, -131072, 0, 1, 0, 1, VERDICT_KEEP);
        add_row(LEARN_LEN, 100, 100, 100, 1, 0, 1, VERDICT_KEEP);
        // invalid input point
        add_row(0, 100, 0, 0, 0, 0, 1, VERDICT_KEEP);
        // invalid background entry takes the point
        add_row(4, 1000, 1000, 1000, 1, 0, 1, VERDICT_KEEP);
        add_row(8, 0, 0, 1, 1, 0, 1, VERDICT_KEEP);
        // both ranges zero
        add_row(3, 0, 0, 0, 1, 0, 1, VERDICT_KEEP);
        // farther than background
        add_row(0, 2000, 0, 0, 1, 0, 1, VERDICT_REMOVE);
        // around the default 0.1 threshold, and at the stored background range
        add_row(5, 0, 0, 0, 1, 0, 0, VERDICT_KEEP);
        add_row(5, 2850, 3800, 0, 1, 0, 0, VERDICT_KEEP);
        add_row(5, 2400, 3200, 0, 1, 0, 0, VERDICT_KEEP);
        add_row(4, 1000, 1000, 1000, 1, 0, 0, VERDICT_KEEP);
        add_row(1, -131072, -131072, -131072, 1, 0, 0, VERDICT_KEEP);
        add_row(2, 131071, 131071, 131071, 1, 1, 0, VERDICT_KEEP);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (point_table[i])
            send_point(point_table[i].pt, point_table[i].typed, point_table[i].verdict);
        s_axis_tvalid <= 1'b0;

        for (int ph = 0; ph < 5; ph++)
        begin
            write_ratio(ratio_set[ph]);
            snd_pct = snd_mode[ph];
            rcv_pct = rcv_mode[ph];
            for (int n = 0; n < PHASE_PTS; n++)
                send_point(random_point(), 1'b0, VERDICT_KEEP);
            s_axis_tvalid <= 1'b0;
        end

        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
